[src/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic task timer table package
// Shared sizes, codes and the slot record type.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int SLOTS = 32;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_DEL_KEY = 2'd2;
  localparam logic [1:0] CMD_DEL_HND = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic KIND_FIRE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic [15:0] handler;
    logic [31:0] key;
    logic [31:0] param;
    logic [15:0] interval;
    logic [31:0] stamp;
  } slot_t;

endpackage

[src/ptt_in_if.sv]
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface ptt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [31:0]        now_sec;
  logic [15:0]        handler_id;
  logic [31:0]        task_key;
  logic [15:0]        interval_sec;
  logic               fire_now;
  logic signed [31:0] task_param;

  modport source (output valid, cmd, now_sec, handler_id, task_key, interval_sec,
                  fire_now, task_param, input ready);
  modport sink (input valid, cmd, now_sec, handler_id, task_key, interval_sec,
                fire_now, task_param, output ready);
endinterface

[src/ptt_out_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one fire or done word.
// ----------------------------------------------------------------------------
interface ptt_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [4:0]         slot;
  logic [15:0]        fired_handler;
  logic signed [31:0] fired_param;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, kind, slot, fired_handler, fired_param, status,
                  last, input ready);
  modport sink (input valid, kind, slot, fired_handler, fired_param, status, last,
                output ready);
endinterface

[src/ptt_cell.sv]
// ----------------------------------------------------------------------------
// Slot cell
// Holds one task slot and takes its neighbour's slot when the ring moves.
// ----------------------------------------------------------------------------
module ptt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  ptt_pkg::slot_t d,
  output ptt_pkg::slot_t q
);

  ptt_pkg::slot_t slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (shift) begin
      slot_r <= d;
    end
  end

  assign q = slot_r;

endmodule

[src/ptt_chain.sv]
// ----------------------------------------------------------------------------
// Slot ring
// Row of slot cells closed into a ring through the slot processor.
// ----------------------------------------------------------------------------
module ptt_chain (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  ptt_pkg::slot_t tail_d,
  output ptt_pkg::slot_t head_q
);

  ptt_pkg::slot_t q [ptt_pkg::SLOTS];

  for (genvar i = 0; i < ptt_pkg::SLOTS; i++) begin : g_cell
    ptt_pkg::slot_t d;
    if (i == ptt_pkg::SLOTS - 1) begin : g_tail
      assign d = tail_d;
    end else begin : g_mid
      assign d = q[i+1];
    end
    ptt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .d     (d),
      .q     (q[i])
    );
  end

  assign head_q = q[0];

endmodule

[src/periodic_task_timer_table.sv]
// Every command except an invalid one makes one pass round the slot ring, one slot
// per cycle while the output is free; invalid-handler commands skip the pass.
// Each command ends in a done word. A fire result that meets a busy output stalls
// the ring while it waits. One command is in work at a time.
// Reset (synchronous, active low) frees every slot and empties the output at once.
// ----------------------------------------------------------------------------
// Periodic task timer table
// Ring of task slots that is scanned by a single slot processor per command.
// ----------------------------------------------------------------------------
module periodic_task_timer_table (
  input logic      clk,
  input logic      rst_n,
  ptt_in_if.sink   in_ch,
  ptt_out_if.source out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PASS = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [ptt_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic                    removed_r, removed_nxt;
  logic                    placed_r, placed_nxt;
  logic [ptt_pkg::IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic                    invalid_r, invalid_nxt;

  logic [1:0]  cmd_r;
  logic [31:0] now_r;
  logic [15:0] hnd_r;
  logic [31:0] key_r;
  logic [15:0] ivl_r;
  logic [31:0] due_r;
  logic        fnow_r;
  logic [31:0] par_r;

  logic        ovalid_r, ovalid_nxt;
  logic        okind_r, okind_nxt;
  logic [4:0]  oslot_r, oslot_nxt;
  logic [15:0] ohnd_r, ohnd_nxt;
  logic [31:0] opar_r, opar_nxt;
  logic [1:0]  ostat_r, ostat_nxt;
  logic        olast_r, olast_nxt;

  ptt_pkg::slot_t head, tail;
  logic out_free, advance, emit, hit, place, accept;
  logic [15:0] ivl_fix;
  logic [32:0] due_sum;

  assign out_free = !ovalid_r || out_ch.ready;
  assign advance  = (state_r == S_PASS) && out_free;
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  ptt_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .shift  (advance),
    .tail_d (tail),
    .head_q (head)
  );

  // Slot processor: works on the slot that sits at the head of the ring.
  always_comb begin
    tail  = head;
    emit  = 1'b0;
    hit   = 1'b0;
    place = 1'b0;
    unique case (cmd_r)
      ptt_pkg::CMD_TICK: begin
        if (head.handler != 16'd0) begin
          if (now_r < head.stamp) begin
            tail.stamp = now_r;
          end else if ((now_r - head.stamp) >= {16'd0, head.interval}) begin
            tail.stamp = now_r;
            emit       = 1'b1;
          end
        end
      end
      ptt_pkg::CMD_ADD: begin
        hit = !removed_r && (head.handler != 16'd0) && (head.handler == hnd_r) &&
              (head.key == key_r);
        if (hit) begin
          tail.handler = 16'd0;
          tail.key     = 32'd0;
        end
        if (!placed_r && (hit || head.handler == 16'd0)) begin
          place         = 1'b1;
          emit          = fnow_r;
          tail.handler  = hnd_r;
          tail.key      = key_r;
          tail.param    = par_r;
          tail.interval = ivl_r;
          tail.stamp    = due_r;
        end
      end
      ptt_pkg::CMD_DEL_KEY, ptt_pkg::CMD_DEL_HND: begin
        hit = !removed_r && (head.handler != 16'd0) && (head.handler == hnd_r) &&
              ((cmd_r == ptt_pkg::CMD_DEL_HND) || (head.key == key_r));
        if (hit) begin
          tail.handler = 16'd0;
          tail.key     = 32'd0;
        end
      end
    endcase
  end

  assign ivl_fix = (in_ch.interval_sec == 16'd0) ? 16'd1 : in_ch.interval_sec;
  assign due_sum = {1'b0, in_ch.now_sec} + {17'd0, ivl_fix};

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    removed_nxt = removed_r;
    placed_nxt  = placed_r;
    res_idx_nxt = res_idx_r;
    invalid_nxt = invalid_r;
    ovalid_nxt  = ovalid_r && !out_ch.ready;
    okind_nxt   = okind_r;
    oslot_nxt   = oslot_r;
    ohnd_nxt    = ohnd_r;
    opar_nxt    = opar_r;
    ostat_nxt   = ostat_r;
    olast_nxt   = olast_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt     = '0;
          removed_nxt = 1'b0;
          placed_nxt  = 1'b0;
          res_idx_nxt = '0;
          invalid_nxt = (in_ch.cmd != ptt_pkg::CMD_TICK) && (in_ch.handler_id == 16'd0);
          state_nxt   = invalid_nxt ? S_DONE : S_PASS;
        end
      end
      S_PASS: begin
        if (advance) begin
          if (hit) begin
            removed_nxt = 1'b1;
            if (cmd_r != ptt_pkg::CMD_ADD) begin
              res_idx_nxt = cnt_r;
            end
          end
          if (place) begin
            placed_nxt  = 1'b1;
            res_idx_nxt = cnt_r;
          end
          if (emit) begin
            ovalid_nxt = 1'b1;
            okind_nxt  = ptt_pkg::KIND_FIRE;
            oslot_nxt  = 5'(cnt_r);
            ohnd_nxt   = place ? hnd_r : head.handler;
            opar_nxt   = place ? par_r : head.param;
            ostat_nxt  = ptt_pkg::ST_OK;
            olast_nxt  = 1'b0;
          end
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == ptt_pkg::IDX_W'(ptt_pkg::SLOTS - 1)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = ptt_pkg::KIND_DONE;
          ohnd_nxt   = 16'd0;
          opar_nxt   = 32'd0;
          olast_nxt  = 1'b1;
          oslot_nxt  = 5'd0;
          if (invalid_r) begin
            ostat_nxt = ptt_pkg::ST_INVALID;
          end else if (cmd_r == ptt_pkg::CMD_TICK) begin
            ostat_nxt = ptt_pkg::ST_OK;
          end else if (cmd_r == ptt_pkg::CMD_ADD) begin
            ostat_nxt = placed_r ? ptt_pkg::ST_OK : ptt_pkg::ST_FULL;
            oslot_nxt = placed_r ? 5'(res_idx_r) : 5'd0;
          end else begin
            ostat_nxt = removed_r ? ptt_pkg::ST_OK : ptt_pkg::ST_NOT_FOUND;
            oslot_nxt = removed_r ? 5'(res_idx_r) : 5'd0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    removed_r <= removed_nxt;
    placed_r  <= placed_nxt;
    res_idx_r <= res_idx_nxt;
    invalid_r <= invalid_nxt;
    okind_r   <= okind_nxt;
    oslot_r   <= oslot_nxt;
    ohnd_r    <= ohnd_nxt;
    opar_r    <= opar_nxt;
    ostat_r   <= ostat_nxt;
    olast_r   <= olast_nxt;
    if (accept) begin
      cmd_r  <= in_ch.cmd;
      now_r  <= in_ch.now_sec;
      hnd_r  <= in_ch.handler_id;
      key_r  <= in_ch.task_key;
      ivl_r  <= ivl_fix;
      due_r  <= due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
      fnow_r <= in_ch.fire_now;
      par_r  <= in_ch.task_param;
    end
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.kind          = okind_r;
  assign out_ch.slot          = oslot_r;
  assign out_ch.fired_handler = ohnd_r;
  assign out_ch.fired_param   = opar_r;
  assign out_ch.status        = ostat_r;
  assign out_ch.last          = olast_r;

endmodule

[verif/ptt_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic task timer table test types
// Command and result records shared by the stimulus table and the checker.
// ----------------------------------------------------------------------------
package ptt_tb_pkg;
  import ptt_pkg::*;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        now_sec;
    logic [15:0]        handler_id;
    logic [31:0]        task_key;
    logic [15:0]        interval_sec;
    logic               fire_now;
    logic signed [31:0] task_param;
  } cmd_word_t;

  typedef struct packed {
    logic               kind;
    logic [4:0]         slot;
    logic [15:0]        fired_handler;
    logic signed [31:0] fired_param;
    logic [1:0]         status;
    logic               last;
  } res_word_t;
endpackage

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic task timer table testbench
// Drives commands through a directed table, a run of adds and then random traffic, predicts
// every fire and done word from a local copy of the slot table, and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import ptt_pkg::*;
  import ptt_tb_pkg::*;

  localparam int N_DIR = 22;
  localparam int N_RAND = 240;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  ptt_in_if in_ch ();
  ptt_out_if out_ch ();

  periodic_task_timer_table uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // Predicted copy of the slot table
  slot_t     tbl [SLOTS];
  res_word_t exp_q [$];
  int        errors = 0;
  bit        calm = 1'b0;
  bit        hold_long = 1'b0;
  bit        stim_done = 1'b0;
  int        idle_cycles = 0;

  cmd_word_t dir_cmd [N_DIR];
  res_word_t dir_res [N_DIR];
  bit        dir_has [N_DIR];

  function automatic res_word_t mk_res(logic k, int s, logic [15:0] h, logic [31:0] p,
                                       logic [1:0] st, logic l);
    res_word_t r;
    r.kind = k;
    r.slot = s[4:0];
    r.fired_handler = h;
    r.fired_param = p;
    r.status = st;
    r.last = l;
    return r;
  endfunction

  function automatic int free_match(logic [15:0] h, logic [31:0] k, bit use_key);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl[i].handler != 0 && tbl[i].handler == h && (!use_key || tbl[i].key == k)) begin
        tbl[i].handler = '0;
        tbl[i].key = '0;
        return i;
      end
    end
    return -1;
  endfunction

  // Pushes the words one command causes and returns how many
  function automatic int predict_table(cmd_word_t c);
    int          idx;
    logic [15:0] iv;
    logic [32:0] due;
    int          n;
    n = 0;
    if (c.cmd == CMD_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl[i].handler == 0) continue;
        if (c.now_sec < tbl[i].stamp) begin
          tbl[i].stamp = c.now_sec;
        end else if (c.now_sec - tbl[i].stamp >= {16'd0, tbl[i].interval}) begin
          tbl[i].stamp = c.now_sec;
          exp_q.push_back(mk_res(KIND_FIRE, i, tbl[i].handler, tbl[i].param, ST_OK, 1'b0));
          n++;
        end
      end
      exp_q.push_back(mk_res(KIND_DONE, 0, 0, 0, ST_OK, 1'b1));
      return n + 1;
    end
    if (c.handler_id == 0) begin
      exp_q.push_back(mk_res(KIND_DONE, 0, 0, 0, ST_INVALID, 1'b1));
      return 1;
    end
    if (c.cmd == CMD_ADD) begin
      void'(free_match(c.handler_id, c.task_key, 1'b1));
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl[i].handler == 0) begin
          iv = (c.interval_sec == 0) ? 16'd1 : c.interval_sec;
          due = {1'b0, c.now_sec} + {17'd0, iv};
          tbl[i].handler = c.handler_id;
          tbl[i].key = c.task_key;
          tbl[i].param = c.task_param;
          tbl[i].interval = iv;
          tbl[i].stamp = due[32] ? 32'hFFFF_FFFF : due[31:0];
          if (c.fire_now) begin
            exp_q.push_back(mk_res(KIND_FIRE, i, c.handler_id, c.task_param, ST_OK, 1'b0));
            n++;
          end
          exp_q.push_back(mk_res(KIND_DONE, i, 0, 0, ST_OK, 1'b1));
          return n + 1;
        end
      end
      exp_q.push_back(mk_res(KIND_DONE, 0, 0, 0, ST_FULL, 1'b1));
      return 1;
    end
    idx = free_match(c.handler_id, c.task_key, c.cmd == CMD_DEL_KEY);
    if (idx < 0) exp_q.push_back(mk_res(KIND_DONE, 0, 0, 0, ST_NOT_FOUND, 1'b1));
    else exp_q.push_back(mk_res(KIND_DONE, idx, 0, 0, ST_OK, 1'b1));
    return 1;
  endfunction

  function automatic cmd_word_t mk_cmd(logic [1:0] op, logic [31:0] t, logic [15:0] h,
                                       logic [31:0] k, logic [15:0] iv, logic f,
                                       logic [31:0] p);
    cmd_word_t c;
    c.cmd = op;
    c.now_sec = t;
    c.handler_id = h;
    c.task_key = k;
    c.interval_sec = iv;
    c.fire_now = f;
    c.task_param = p;
    return c;
  endfunction

  // A small pool of handlers and keys keeps deletes and re-adds hitting live slots
  function automatic cmd_word_t rand_cmd(ref logic [31:0] clock_sec);
    cmd_word_t c;
    int        r;
    c.cmd = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 70) clock_sec = clock_sec + $urandom_range(0, 4);
    else if (r < 80) clock_sec = clock_sec - $urandom_range(0, 20);
    else if (r < 85) clock_sec = $urandom;
    c.now_sec = clock_sec;
    r = $urandom_range(0, 19);
    c.handler_id = (r == 0) ? 16'd0 : (r < 16) ? 16'($urandom_range(1, 12)) : 16'($urandom);
    c.task_key = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 3)) : $urandom;
    c.interval_sec = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 6)) : 16'($urandom);
    c.fire_now = 1'($urandom_range(0, 1));
    c.task_param = $urandom;
    if ($urandom_range(0, 9) < 3) c.cmd = CMD_ADD;
    return c;
  endfunction

  initial begin
    int n;
    n = 0;
    // Fresh table: tick, invalid handlers, deletes of nothing
    dir_cmd[n] = mk_cmd(CMD_TICK, 32'd0, 0, 0, 0, 0, 0);
    dir_res[n] = mk_res(KIND_DONE, 0, 0, 0, ST_OK, 1); dir_has[n++] = 1;
    dir_cmd[n] = mk_cmd(CMD_ADD, 32'd5, 16'd0, 32'd1, 16'd3, 1, 32'd9);
    dir_res[n] = mk_res(KIND_DONE, 0, 0, 0, ST_INVALID, 1); dir_has[n++] = 1;
    dir_cmd[n] = mk_cmd(CMD_DEL_KEY, 0, 16'd0, 0, 0, 0, 0);
    dir_res[n] = mk_res(KIND_DONE, 0, 0, 0, ST_INVALID, 1); dir_has[n++] = 1;
    dir_cmd[n] = mk_cmd(CMD_DEL_HND, 0, 16'd0, 0, 0, 0, 0);
    dir_res[n] = mk_res(KIND_DONE, 0, 0, 0, ST_INVALID, 1); dir_has[n++] = 1;
    dir_cmd[n] = mk_cmd(CMD_DEL_HND, 0, 16'hFFFF, 0, 0, 0, 0);
    dir_res[n] = mk_res(KIND_DONE, 0, 0, 0, ST_NOT_FOUND, 1); dir_has[n++] = 1;
    // Extremes: zero interval, saturating due time, fire now
    dir_cmd[n] = mk_cmd(CMD_ADD, 32'd10, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 1, 32'h8000_0000);
    dir_has[n++] = 0;
    dir_cmd[n] = mk_cmd(CMD_ADD, 32'hFFFF_FFF0, 16'd1, 32'd0, 16'hFFFF, 0, 32'h7FFF_FFFF);
    dir_has[n++] = 0;
    dir_cmd[n] = mk_cmd(CMD_ADD, 32'd10, 16'hFFFF, 32'hFFFF_FFFF, 16'd2, 1, 32'd5);
    dir_has[n++] = 0;
    dir_cmd[n] = mk_cmd(CMD_TICK, 32'd11, 0, 0, 0, 0, 0); dir_has[n++] = 0;
    dir_cmd[n] = mk_cmd(CMD_TICK, 32'd12, 0, 0, 0, 0, 0); dir_has[n++] = 0;
    dir_cmd[n] = mk_cmd(CMD_TICK, 32'd12, 0, 0, 0, 0, 0); dir_has[n++] = 0;
    dir_cmd[n] = mk_cmd(CMD_TICK, 32'd3, 0, 0, 0, 0, 0); dir_has[n++] = 0;
    dir_cmd[n] = mk_cmd(CMD_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0); dir_has[n++] = 0;
    dir_cmd[n] = mk_cmd(CMD_DEL_KEY, 0, 16'hFFFF, 32'd7, 0, 0, 0); dir_has[n++] = 0;
    dir_cmd[n] = mk_cmd(CMD_DEL_KEY, 0, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0); dir_has[n++] = 0;
    dir_cmd[n] = mk_cmd(CMD_DEL_HND, 0, 16'd1, 32'd99, 0, 0, 0); dir_has[n++] = 0;
    // Add four tasks, tick them, then clear a slot
    for (int i = 0; i < 4; i++) begin
      dir_cmd[n] = mk_cmd(CMD_ADD, 32'd20, 16'(100 + i), 32'(i), 16'd1, 0, 32'(i));
      dir_has[n++] = 0;
    end
    dir_cmd[n] = mk_cmd(CMD_TICK, 32'd21, 0, 0, 0, 0, 0); dir_has[n++] = 0;
    dir_cmd[n] = mk_cmd(CMD_DEL_HND, 0, 16'd102, 0, 0, 0, 0); dir_has[n++] = 0;
  end

  // Sender
  initial begin
    cmd_word_t  c;
    logic [31:0] clock_sec;
    int          gap;
    in_ch.valid <= 1'b0;
    {in_ch.cmd, in_ch.now_sec, in_ch.handler_id, in_ch.task_key,
     in_ch.interval_sec, in_ch.fire_now, in_ch.task_param} <= '0;
    for (int i = 0; i < SLOTS; i++) tbl[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    clock_sec = 32'd100;
    for (int i = 0; i < N_DIR + N_RAND + 40; i++) begin
      if (i < N_DIR) c = dir_cmd[i];
      else if (i < N_DIR + 40) c = mk_cmd(CMD_ADD, clock_sec, 16'(200 + i), 32'(i), 16'd1,
                                          i[0], $urandom);
      else c = rand_cmd(clock_sec);
      if (i == N_DIR + 40) hold_long = 1'b1;
      if (i == N_DIR + 40 + N_RAND - 60) calm = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 7);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      {in_ch.cmd, in_ch.now_sec, in_ch.handler_id, in_ch.task_key,
       in_ch.interval_sec, in_ch.fire_now, in_ch.task_param} <= c;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      if (i < N_DIR && dir_has[i]) begin
        void'(predict_table(c));
        if (exp_q[$] !== dir_res[i]) begin
          $display("%0t: table row %0d expected %h, model gives %h", $time, i, dir_res[i],
                   exp_q[$]);
          errors++;
        end
      end else begin
        void'(predict_table(c));
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 7);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Checker and watchdog
  always @(posedge clk) begin
    res_word_t got, want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.kind, out_ch.slot, out_ch.fired_handler, out_ch.fired_param,
               out_ch.status, out_ch.last};
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          want = exp_q.pop_front();
          if (got.kind !== want.kind || got.slot !== want.slot ||
              got.fired_handler !== want.fired_handler ||
              got.fired_param !== want.fired_param || got.status !== want.status ||
              got.last !== want.last) begin
            $display("%0t: expected %h, actual %h", $time, want, got);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (exp_q.size() != 0 && idle_cycles < STALL_LIMIT) @(posedge clk);
    if (exp_q.size() == 0) begin
      repeat (40) @(posedge clk);
      if (errors == 0 && exp_q.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end
endmodule
